[hw/rtl/tkm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k merge package
// Shared widths, register map, defaults and the kept-entry type.
// ----------------------------------------------------------------------------
package tkm_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned RANK_W       = 4;
  localparam int unsigned KEEP_W       = 5;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned APB_ADDR_W   = 3;
  localparam int unsigned MAX_KEEP_DEF = 16;

  localparam logic [KEEP_W-1:0] KEEP_COUNT_RST = 5'd10;

  // register index, taken from paddr above the byte offset
  localparam logic REG_KEEP_COUNT = 1'b0;

  typedef struct packed {
    logic signed [DATA_W-1:0] distance;
    logic        [DATA_W-1:0] id;
  } kept_entry_t;

endpackage

[hw/rtl/tkm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tkm_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/tkm_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k insertion engine
// Sequencer around one signed comparator and the kept-hit RAM: sorted insert
// by backward shift, then emission of the kept list.
// ----------------------------------------------------------------------------
module tkm_engine #(
  parameter int unsigned MaxKeep = 16,
  localparam int unsigned IdxW = (MaxKeep > 1) ? $clog2(MaxKeep) : 1,
  localparam int unsigned CntW = $clog2(MaxKeep + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [CntW-1:0]                     k_i,
  input  logic                                start,
  output logic                                busy,
  input  logic [tkm_pkg::DATA_W-1:0]          hit_id_i,
  input  logic signed [tkm_pkg::DATA_W-1:0]   hit_distance_i,
  input  logic                                set_end_i,
  output logic                                out_valid_o,
  output logic [tkm_pkg::DATA_W-1:0]          out_id_o,
  output logic signed [tkm_pkg::DATA_W-1:0]   out_distance_o,
  output logic [tkm_pkg::RANK_W-1:0]          out_rank_o,
  output logic                                out_last_o
);
  import tkm_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CHK_RD  = 3'd1;
  localparam logic [2:0] S_CHK     = 3'd2;
  localparam logic [2:0] S_SHF_RD  = 3'd3;
  localparam logic [2:0] S_SHF     = 3'd4;
  localparam logic [2:0] S_PUT     = 3'd5;
  localparam logic [2:0] S_EMIT_RD = 3'd6;
  localparam logic [2:0] S_EMIT    = 3'd7;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] idx_q, idx_d;
  kept_entry_t     hit_q, hit_d;
  logic            end_q, end_d;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  kept_entry_t     wdata, rdata;
  logic [CntW-1:0] cnt_clamp;
  logic            worse;
  logic [IdxW-1:0] k_last;
  logic            emit_last;

  tkm_ram #(
    .Width($bits(kept_entry_t)),
    .Depth(MaxKeep)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // shared comparator: stored entry strictly farther than the new hit
  assign worse     = $signed(rdata.distance) > $signed(hit_q.distance);
  assign cnt_clamp = (cnt_q > k_i) ? k_i : cnt_q;
  assign k_last    = IdxW'(k_i - CntW'(1));
  assign emit_last = (CntW'(idx_q) + CntW'(1)) == cnt_q;

  assign busy           = state_q != S_IDLE;
  assign out_valid_o    = state_q == S_EMIT;
  assign out_id_o       = rdata.id;
  assign out_distance_o = rdata.distance;
  assign out_rank_o     = RANK_W'(idx_q);
  assign out_last_o     = emit_last;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    hit_d   = hit_q;
    end_d   = end_q;
    we      = 1'b0;
    waddr   = idx_q;
    wdata   = hit_q;
    raddr   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          hit_d.id       = hit_id_i;
          hit_d.distance = hit_distance_i;
          end_d          = set_end_i;
          if (cnt_clamp < k_i) begin
            cnt_d = cnt_clamp + CntW'(1);
            idx_d = IdxW'(cnt_clamp);
            state_d = (cnt_clamp == '0) ? S_PUT : S_SHF_RD;
          end else begin
            cnt_d   = cnt_clamp;
            state_d = S_CHK_RD;
          end
        end
      end
      S_CHK_RD: begin
        raddr   = k_last;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (worse) begin
          // drop the worst entry by overwriting it
          idx_d   = k_last;
          state_d = (k_last == '0) ? S_PUT : S_SHF_RD;
        end else begin
          state_d = end_q ? S_EMIT_RD : S_IDLE;
          idx_d   = '0;
        end
      end
      S_SHF_RD: begin
        raddr   = idx_q - IdxW'(1);
        state_d = S_SHF;
      end
      S_SHF: begin
        we    = 1'b1;
        waddr = idx_q;
        if (worse) begin
          wdata   = rdata;
          idx_d   = idx_q - IdxW'(1);
          state_d = (idx_q == IdxW'(1)) ? S_PUT : S_SHF_RD;
        end else begin
          wdata   = hit_q;
          idx_d   = '0;
          state_d = end_q ? S_EMIT_RD : S_IDLE;
        end
      end
      S_PUT: begin
        we      = 1'b1;
        waddr   = idx_q;
        wdata   = hit_q;
        idx_d   = '0;
        state_d = end_q ? S_EMIT_RD : S_IDLE;
      end
      S_EMIT_RD: begin
        raddr   = idx_q;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (emit_last) begin
          cnt_d   = '0;
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d   = idx_q + IdxW'(1);
          state_d = S_EMIT_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      end_q   <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
  end

endmodule

[hw/rtl/top_k_smallest_distance_merge_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k smallest-distance merge core
// Keeps the k closest hits of a set in sorted order and emits them, closest
// first, on the last hit of the set.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  ----------------------------
// hit       in         start & !busy             hit_id_i, hit_distance_i,
//                                                set_end_i
// result    out        out_valid_o (1 cycle)     out_id_o, out_distance_o,
//                                                out_rank_o, out_last_o
// config    in         psel & penable & pwrite   paddr, pwdata (keep_count)
//
// Per hit: when the list is full, the worst entry is read and then checked; a
// hit that is not closer stops there. An entering hit then walks back from
// the tail, each entry compared being read, then compared and written, plus
// a final write only when the hit lands at the front. A set-end hit then
// reads and emits each kept result in turn. The kept-hit RAM with one read
// and one write port and registered read data, and its one comparator, set
// this sequence.
// Reset: asynchronous, active low; clears the list count and sets k to 10.
// The kept-hit RAM needs no clearing pass, since only filled entries are read.
// Stalls: busy stays high for the whole hit; results cannot be held off.
//
module top_k_smallest_distance_merge_core #(
  parameter int unsigned MaxKeep = tkm_pkg::MAX_KEEP_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // hit transfer
  input  logic                                  start,
  output logic                                  busy,
  input  logic [tkm_pkg::DATA_W-1:0]            hit_id_i,
  input  logic signed [tkm_pkg::DATA_W-1:0]     hit_distance_i,
  input  logic                                  set_end_i,
  // result transfer
  output logic                                  out_valid_o,
  output logic [tkm_pkg::DATA_W-1:0]            out_id_o,
  output logic signed [tkm_pkg::DATA_W-1:0]     out_distance_o,
  output logic [tkm_pkg::RANK_W-1:0]            out_rank_o,
  output logic                                  out_last_o,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tkm_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [tkm_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [tkm_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                  pready
);
  import tkm_pkg::*;

  localparam int unsigned CntW = $clog2(MaxKeep + 1);

  logic [KEEP_W-1:0] keep_count_q, keep_count_d;
  logic              sel_keep;
  logic [CntW-1:0]   k_eff;

  // register select: word address above the byte offset
  assign sel_keep = paddr[APB_ADDR_W-1] == REG_KEEP_COUNT;
  assign pready   = 1'b1;

  always_comb begin
    keep_count_d = keep_count_q;
    if (psel && penable && pwrite && sel_keep) begin
      keep_count_d = pwdata[KEEP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_keep) begin
      prdata = APB_DATA_W'(keep_count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_count_q <= KEEP_COUNT_RST;
    end else begin
      keep_count_q <= keep_count_d;
    end
  end

  // Effective k: zero counts as one, anything above the list depth saturates.
  always_comb begin
    if (keep_count_q == '0) begin
      k_eff = CntW'(1);
    end else if (32'(keep_count_q) > MaxKeep) begin
      k_eff = CntW'(MaxKeep);
    end else begin
      k_eff = CntW'(keep_count_q);
    end
  end

  tkm_engine #(
    .MaxKeep(MaxKeep)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .k_i           (k_eff),
    .start         (start),
    .busy          (busy),
    .hit_id_i      (hit_id_i),
    .hit_distance_i(hit_distance_i),
    .set_end_i     (set_end_i),
    .out_valid_o   (out_valid_o),
    .out_id_o      (out_id_o),
    .out_distance_o(out_distance_o),
    .out_rank_o    (out_rank_o),
    .out_last_o    (out_last_o)
  );

endmodule

[sim/top_k_smallest_distance_merge_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-k smallest-distance merge core testbench
// Streams sets of hits into the core under several keep counts, predicts the
// sorted closest-first list that each set-end hit emits, and checks every
// emitted entry field by field as it appears on the result strobe.
// ----------------------------------------------------------------------------
module top_k_smallest_distance_merge_core_test;
  import tkm_pkg::*;

  localparam int unsigned MAX_KEEP    = MAX_KEEP_DEF;
  // Longest hit plus the emission of a full list, rounded up for settling.
  localparam int unsigned SETTLE      = 2 * MAX_KEEP + 2 + 2 * MAX_KEEP + 8;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RAND_HITS   = 250;
  localparam logic [APB_ADDR_W-1:0] KEEP_ADDR = {REG_KEEP_COUNT, 2'b00};

  typedef struct {
    logic [DATA_W-1:0]        id;
    logic signed [DATA_W-1:0] distance;
    logic [RANK_W-1:0]        rank;
    logic                     last;
  } ranked_hit_t;

  // Keeps its own sorted closest-hit list and the ranked entries still owed.
  class nearest_hits_board;
    logic signed [DATA_W-1:0] list_dist [MAX_KEEP];
    logic [DATA_W-1:0]        list_id [MAX_KEEP];
    int unsigned              list_len;
    logic [KEEP_W-1:0]        keep_reg;
    ranked_hit_t              owed_q [$];
    int unsigned              errors;
    int unsigned              checked;

    function new();
      list_len = 0;
      keep_reg = KEEP_COUNT_RST;
      errors   = 0;
      checked  = 0;
    endfunction

    function void set_keep(logic [KEEP_W-1:0] k);
      keep_reg = k;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    // Sorted insert of one accepted hit; on a set end, queue the ranked list.
    function void take_hit(logic [DATA_W-1:0] id, logic signed [DATA_W-1:0] distance,
                           logic set_end);
      int unsigned k;
      int unsigned pos;
      int unsigned tail;
      int unsigned i;
      bit          enters;
      ranked_hit_t e;
      k = (keep_reg == 0) ? 1 : ((keep_reg > MAX_KEEP) ? MAX_KEEP : keep_reg);
      if (list_len > k) list_len = k;
      pos = 0;
      while (pos < list_len && list_dist[pos] <= distance) pos++;
      enters = 1'b1;
      if (list_len < k) begin
        tail = list_len;
        list_len++;
      end else if (pos < k) begin
        tail = k - 1;
      end else begin
        enters = 1'b0;
      end
      if (enters) begin
        for (i = tail; i > pos; i--) begin
          list_dist[i] = list_dist[i-1];
          list_id[i]   = list_id[i-1];
        end
        list_dist[pos] = distance;
        list_id[pos]   = id;
      end
      if (set_end) begin
        for (i = 0; i < list_len; i++) begin
          e.id       = list_id[i];
          e.distance = list_dist[i];
          e.rank     = i[RANK_W-1:0];
          e.last     = (i + 1 == list_len);
          owed_q     = {owed_q, e};
        end
        list_len = 0;
      end
    endfunction

    function void match_result(logic [DATA_W-1:0] id, logic signed [DATA_W-1:0] distance,
                               logic [RANK_W-1:0] rank, logic last);
      ranked_hit_t e;
      checked++;
      if (owed_q.size() == 0) begin
        flag($sformatf("unexpected result id=%h distance=%h rank=%0d last=%0b",
                       id, distance, rank, last));
        return;
      end
      e = owed_q.pop_front();
      if (id !== e.id || distance !== e.distance || rank !== e.rank || last !== e.last)
        flag($sformatf({"result exp id=%h distance=%h rank=%0d last=%0b, ",
                        "got id=%h distance=%h rank=%0d last=%0b"},
                       e.id, e.distance, e.rank, e.last, id, distance, rank, last));
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [DATA_W-1:0]        hit_id_i;
  logic signed [DATA_W-1:0] hit_distance_i;
  logic                     set_end_i;
  logic                     out_valid_o;
  logic [DATA_W-1:0]        out_id_o;
  logic signed [DATA_W-1:0] out_distance_o;
  logic [RANK_W-1:0]        out_rank_o;
  logic                     out_last_o;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0]    pwdata;
  logic [APB_DATA_W-1:0]    prdata;
  logic                     pready;

  nearest_hits_board board = new();
  int unsigned hits_sent;
  int unsigned sets_sent;
  int unsigned keep_writes;
  int unsigned quiet_cycles;
  bit          no_gaps;

  top_k_smallest_distance_merge_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .hit_id_i       (hit_id_i),
    .hit_distance_i (hit_distance_i),
    .set_end_i      (set_end_i),
    .out_valid_o    (out_valid_o),
    .out_id_o       (out_id_o),
    .out_distance_o (out_distance_o),
    .out_rank_o     (out_rank_o),
    .out_last_o     (out_last_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Sample both transfers at the edge that accepts them. Check results before
  // noting a new hit: a hit never produces a result at its own accept edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o)
        board.match_result(out_id_o, out_distance_o, out_rank_o, out_last_o);
      if (start && !busy)
        board.take_hit(hit_id_i, hit_distance_i, set_end_i);
    end
  end

  // Watchdog: count cycles in which no transfer of any kind completes.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || out_valid_o || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] ERROR: no transfer for %0d cycles", $realtime, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly back-to-back, some short pauses, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Full-range values, a narrow band that forces ties, or values at the rails.
  function automatic logic signed [DATA_W-1:0] pick_distance();
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode < 5) return $urandom;
    if (mode < 8) return $signed($urandom_range(0, 7)) - 4;
    case ($urandom_range(0, 6))
      0: return 32'sh8000_0000;
      1: return 32'sh8000_0001;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32'sh7FFF_FFFE;
      default: return 32'sh7FFF_FFFF;
    endcase
  endfunction

  // Present one hit, hold it until the transfer, then optionally drop start.
  task automatic send_hit(input logic [DATA_W-1:0] id,
                          input logic signed [DATA_W-1:0] distance,
                          input logic last, input int unsigned gap);
    start          <= 1'b1;
    hit_id_i       <= id;
    hit_distance_i <= distance;
    set_end_i      <= last;
    do @(posedge clk_i); while (busy);
    hits_sent++;
    if (last) sets_sent++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off the sender until every owed result is out and the core is quiet.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0 || busy);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Idle the core, write keep_count, then read it back.
  task automatic write_keep(input logic [KEEP_W-1:0] k);
    logic [APB_DATA_W-1:0] rd;
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= KEEP_ADDR;
    pwdata  <= APB_DATA_W'(k);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_keep(k);
    keep_writes++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== APB_DATA_W'(k))
      board.flag($sformatf("keep_count readback exp %0d got %h", k, rd));
  endtask

  // One random set; sometimes change keep_count halfway through it.
  task automatic send_set(input int unsigned len);
    int unsigned i;
    bit          retune;
    retune = ($urandom_range(0, 5) == 0) && len > 1;
    for (i = 0; i < len; i++) begin
      if (retune && i == len / 2) write_keep(KEEP_W'($urandom_range(0, 31)));
      send_hit($urandom, pick_distance(), i + 1 == len, pick_gap());
    end
  endtask

  initial begin
    logic [KEEP_W-1:0] phase_keep [8];
    int unsigned       p;
    int unsigned       budget;
    int unsigned       len;
    int unsigned       i;

    rst_ni         = 1'b0;
    start          = 1'b0;
    hit_id_i       = '0;
    hit_distance_i = '0;
    set_end_i      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    hits_sent      = 0;
    sets_sent      = 0;
    keep_writes    = 0;
    quiet_cycles   = 0;
    no_gaps        = 1'b1;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset keep count of 10: fill past k with rails, ties, a rejected tie
    // with the worst entry, and a final hit that evicts the worst.
    send_hit(32'hFFFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 0);
    send_hit(32'h0000_0000, 32'sh8000_0000, 1'b0, 0);
    send_hit(32'd5, 32'sh0000_0000, 1'b0, 0);
    send_hit(32'd6, -32'sd1, 1'b0, 2);
    send_hit(32'd7, 32'sh0005_0000, 1'b0, 0);
    send_hit(32'd8, 32'sh0005_0000, 1'b0, 0);
    send_hit(32'd9, 32'sh0000_0001, 1'b0, 0);
    send_hit(32'd10, -32'sh0001_0000, 1'b0, 0);
    send_hit(32'd11, 32'sh0005_0000, 1'b0, 0);
    send_hit(32'd12, 32'sh7FFF_FFFE, 1'b0, 0);
    send_hit(32'd13, 32'sh7FFF_FFFF, 1'b0, 0);
    send_hit(32'd14, 32'sh0003_0000, 1'b1, 0);
    // Single-hit set.
    send_hit(32'h5A5A_5A5A, 32'sh0001_8000, 1'b1, 0);

    // k = 1: an equal distance loses to the earlier hit, a smaller one wins.
    write_keep(5'd1);
    send_hit(32'd100, 32'sd7, 1'b0, 0);
    send_hit(32'd101, 32'sd7, 1'b1, 0);
    send_hit(32'd200, 32'sd9, 1'b0, 0);
    send_hit(32'd201, 32'sd3, 1'b1, 0);

    // Lower k mid-set: the worst kept hits go before the next hit counts.
    write_keep(5'd16);
    for (i = 0; i < 5; i++) send_hit($urandom, pick_distance(), 1'b0, 0);
    write_keep(5'd2);
    send_hit($urandom, pick_distance(), 1'b1, 0);

    // Random phases: the extremes of keep_count first, zero and out-of-range
    // included, then random settings. Every third phase runs without gaps.
    phase_keep = '{5'd16, 5'd0, 5'd31, 5'd3, 5'd1, 5'd10, 5'd0, 5'd0};
    phase_keep[6] = KEEP_W'($urandom_range(0, 31));
    phase_keep[7] = KEEP_W'($urandom_range(0, 31));
    for (p = 0; p < 8; p++) begin
      write_keep(phase_keep[p]);
      no_gaps = (p % 3 == 2);
      budget  = hits_sent + RAND_HITS / 8;
      while (hits_sent < budget) begin
        if ($urandom_range(0, 7) == 0) len = $urandom_range(1, 24);
        else len = $urandom_range(1, 8);
        send_set(len);
      end
    end

    drain();
    if (board.pending() != 0)
      board.flag($sformatf("%0d results never arrived", board.pending()));

    $display("Covered %0d hits in %0d sets, %0d results checked, %0d keep_count writes",
             hits_sent, sets_sent, board.checked, keep_writes);
    $display("Keep counts from zero to 31, with ties, rail distances and mid-set changes");
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[top_k_smallest_distance_merge_core.f]
hw/rtl/tkm_pkg.sv
hw/rtl/tkm_ram.sv
hw/rtl/tkm_engine.sv
hw/rtl/top_k_smallest_distance_merge_core.sv
sim/top_k_smallest_distance_merge_core_test.sv
